### rtl/core/sbr_pkg.sv
package sbr_pkg;

    typedef logic [7:0] byte_t;

    localparam logic [31:0] COOKIE      = 32'h2112_A442;
    localparam logic [15:0] REQ_TYPE    = 16'h0001;
    localparam logic [15:0] RESP_TYPE   = 16'h0101;
    localparam logic [15:0] ATTR_XMA    = 16'h0020;
    localparam byte_t       FAMILY_V4   = 8'h01;
    localparam byte_t       MSG_LEN     = 8'd12;
    localparam byte_t       ATTR_LEN    = 8'd8;
    localparam int          TID_BYTES   = 12;
    localparam int          RESP_BYTES  = 32;

    // everything the back end needs to build one response
    typedef struct packed {
        logic [TID_BYTES-1:0][7:0] tid;   // tid[0] is the first id byte
        logic [15:0]               xport;
        logic [31:0]               xip;
    } job_t;

endpackage

### rtl/core/sbr_front.sv
module sbr_front
    import sbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // in_byte [7:0], src_ip [39:8], src_port [55:40]
    input  logic        s_tlast,
    output logic        push_valid,
    input  logic        push_ready,
    output job_t        push_job
);

    localparam logic [4:0] COUNT_MAX  = 5'd31;
    localparam logic [4:0] COOKIE_POS = 5'd4;
    localparam logic [4:0] TID_POS    = 5'd8;
    localparam logic [4:0] TID_END    = 5'd19;

    logic [4:0] count_reg, count_next;
    logic       type_ok_reg, type_ok_next;
    logic       cookie_ok_reg, cookie_ok_next;
    byte_t      tid_reg [TID_BYTES];

    byte_t       in_byte;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic        accept;
    logic [1:0]  cookie_k;
    byte_t       type_want;
    byte_t       cookie_want;

    assign in_byte  = s_tdata[7:0];
    assign src_ip   = s_tdata[39:8];
    assign src_port = s_tdata[55:40];

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    assign cookie_k    = count_reg[1:0];
    assign type_want   = count_reg[0] ? REQ_TYPE[7:0] : REQ_TYPE[15:8];
    assign cookie_want = byte_t'(COOKIE >> {~cookie_k, 3'b000});

    always_comb begin
        count_next     = count_reg;
        type_ok_next   = type_ok_reg;
        cookie_ok_next = cookie_ok_reg;
        if (accept) begin
            if (count_reg < 5'd2) begin
                if (in_byte != type_want) type_ok_next = 1'b0;
            end else if (count_reg >= COOKIE_POS && count_reg < TID_POS) begin
                if (in_byte != cookie_want) cookie_ok_next = 1'b0;
            end
            if (count_reg < COUNT_MAX) count_next = count_reg + 5'd1;
            if (s_tlast) begin
                count_next     = '0;
                type_ok_next   = 1'b1;
                cookie_ok_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            type_ok_reg   <= 1'b1;
            cookie_ok_reg <= 1'b1;
        end else begin
            count_reg     <= count_next;
            type_ok_reg   <= type_ok_next;
            cookie_ok_reg <= cookie_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TID_BYTES; i++) begin
            if (accept && count_reg == TID_POS + 5'(i)) tid_reg[i] <= in_byte;
        end
    end

    // the last id byte may be the one arriving now
    always_comb begin
        for (int i = 0; i < TID_BYTES; i++) begin
            push_job.tid[i] = tid_reg[i];
        end
        if (count_reg == TID_END) push_job.tid[TID_BYTES-1] = in_byte;
        push_job.xport = src_port ^ COOKIE[31:16];
        push_job.xip   = src_ip ^ COOKIE;
    end

    // match flags are final once the header is past the cookie
    assign push_valid = accept && s_tlast && count_reg >= TID_END
                        && type_ok_reg && cookie_ok_reg;

endmodule

### rtl/core/sbr_queue.sv
module sbr_queue
    import sbr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int         PTR_W  = $clog2(DEPTH);
    localparam int         CNT_W  = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)      count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/core/sbr_back.sv
module sbr_back
    import sbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast
);

    localparam logic [4:0] LAST_IDX = 5'(RESP_BYTES - 1);

    logic [4:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    byte_t      data_reg;
    logic       last_reg;
    logic       load;

    function automatic byte_t resp_byte(job_t j, logic [4:0] idx);
        logic [3:0] t;
        logic [1:0] k;
        byte_t      b;
        t = 4'(idx - 5'd8);
        k = idx[1:0];
        case (idx) inside
            5'd0:           b = RESP_TYPE[15:8];
            5'd1:           b = RESP_TYPE[7:0];
            5'd2:           b = 8'h00;
            5'd3:           b = MSG_LEN;
            [5'd4:5'd7]:    b = byte_t'(COOKIE >> {~k, 3'b000});
            [5'd8:5'd19]:   b = j.tid[t];
            5'd20:          b = ATTR_XMA[15:8];
            5'd21:          b = ATTR_XMA[7:0];
            5'd22:          b = 8'h00;
            5'd23:          b = ATTR_LEN;
            5'd24:          b = 8'h00;
            5'd25:          b = FAMILY_V4;
            5'd26:          b = j.xport[15:8];
            5'd27:          b = j.xport[7:0];
            [5'd28:5'd31]:  b = byte_t'(j.xip >> {~k, 3'b000});
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

    // output register refills whenever it is empty or being taken
    assign load      = !valid_reg || m_tready;
    assign job_ready = load && idx_reg == LAST_IDX;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = job_valid;
            if (job_valid) idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && job_valid) begin
            data_reg <= resp_byte(job, idx_reg);
            last_reg <= idx_reg == LAST_IDX;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/core/stun_binding_responder.sv
// stun binding responder: takes a udp payload one byte per cycle and, for every
// binding request of at least 20 bytes with the right type and magic cookie, sends
// a 32-byte binding success response with the transaction id echoed and an
// xor-mapped-address built from the sender ip and port (sampled with the last
// byte). input runs at one byte per cycle; each response then streams out at one
// byte per cycle from the serialiser while m_tready is high. a queue of QUEUE_DEPTH
// pending responses sits between the parser and the serialiser, and s_tready
// drops only while that queue is full, so bursts of short requests stall input.
// the job is registered in a queue slot, each response byte in the output register.
module stun_binding_responder
    import sbr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // in_byte [7:0], src_ip [39:8], src_port [55:40]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast
);

    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    sbr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sbr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### sim/stun_binding_responder_test.sv
`timescale 1ns / 100ps

module stun_binding_responder_test;
    import sbr_pkg::*;

    localparam int         HALF_PERIOD  = 1;
    localparam int         RESET_CYCLES = 11;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         RANDOM_BYTES = 80;
    localparam int         CALM_BYTES   = 30;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         HDR_BYTES    = 20;
    localparam logic [4:0] COUNT_MAX    = 5'd31;

    typedef struct packed {
        byte_t data;
        logic  last;
    } resp_octet_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // in_byte [7:0], src_ip [39:8], src_port [55:40]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte [7:0]
    logic        m_tlast;

    // parser state as the block should hold it
    logic [4:0]  rx_count  = 5'd0;
    logic        type_ok   = 1'b1;
    logic        cookie_ok = 1'b1;
    byte_t       txn_id [TID_BYTES];

    resp_octet_t response_due [$];
    byte_t       pkt [$];
    int          mismatches  = 0;
    int          sent_bytes  = 0;
    int          idle_cycles = 0;
    logic        calm        = 1'b0;
    logic        hold_req    = 1'b0;

    stun_binding_responder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic predict_response(input logic [55:0] data, input logic eop);
        byte_t       octet;
        int          pos;
        int          i;
        logic [15:0] xport;
        logic [31:0] xip;
        byte_t       resp [RESP_BYTES];
        resp_octet_t r;
        octet = data[7:0];
        pos   = rx_count;
        if (pos < 2) begin
            if (octet != byte_t'(REQ_TYPE >> (8 * (1 - pos)))) type_ok = 1'b0;
        end else if (pos >= 4 && pos < 8) begin
            if (octet != byte_t'(COOKIE >> (8 * (7 - pos)))) cookie_ok = 1'b0;
        end else if (pos >= 8 && pos < HDR_BYTES) begin
            txn_id[pos - 8] = octet;
        end
        // count sticks at 31 on long datagrams
        if (rx_count != COUNT_MAX) rx_count = rx_count + 5'd1;
        if (eop) begin
            if (pos + 1 >= HDR_BYTES && type_ok && cookie_ok) begin
                xport    = data[55:40] ^ COOKIE[31:16];
                xip      = data[39:8] ^ COOKIE;
                resp[0]  = RESP_TYPE[15:8];
                resp[1]  = RESP_TYPE[7:0];
                resp[2]  = 8'h00;
                resp[3]  = MSG_LEN;
                for (i = 0; i < 4; i++) resp[4 + i] = COOKIE[31 - 8 * i -: 8];
                for (i = 0; i < TID_BYTES; i++) resp[8 + i] = txn_id[i];
                resp[20] = ATTR_XMA[15:8];
                resp[21] = ATTR_XMA[7:0];
                resp[22] = 8'h00;
                resp[23] = ATTR_LEN;
                resp[24] = 8'h00;
                resp[25] = FAMILY_V4;
                resp[26] = xport[15:8];
                resp[27] = xport[7:0];
                for (i = 0; i < 4; i++) resp[28 + i] = xip[31 - 8 * i -: 8];
                for (i = 0; i < RESP_BYTES; i++) begin
                    r.data = resp[i];
                    r.last = (i == RESP_BYTES - 1);
                    response_due.push_back(r);
                end
            end
            rx_count  = 5'd0;
            type_ok   = 1'b1;
            cookie_ok = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) predict_response(s_tdata, s_tlast);
    end

    always @(posedge aclk) begin : check_response
        resp_octet_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (response_due.size() == 0) begin
                $display("%0t: unexpected response byte, expected none, got %02h last %0b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = response_due.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last mismatch, expected %0b, got %0b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("stun_binding_responder_test failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on demand
    initial begin : sink
        int   idle_left;
        int   hold_left;
        logic hold_seen;
        idle_left = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_tready = 1'b0;
                idle_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready  = 1'b0;
                idle_left = $urandom_range(1, 11) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_request(input byte_t octet, input logic eop,
                                input logic [31:0] ip, input logic [15:0] port);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap      = $urandom_range(1, 11);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {port, ip, octet};
        s_tlast  = eop;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // wander: address fields move on every byte but the last
    task automatic send_datagram(input logic [31:0] ip, input logic [15:0] port,
                                 input logic wander);
        int i;
        for (i = 0; i < pkt.size(); i++) begin
            if (wander && i != pkt.size() - 1)
                send_request(pkt[i], 1'b0, $urandom, 16'($urandom));
            else
                send_request(pkt[i], i == pkt.size() - 1, ip, port);
        end
        sent_bytes += pkt.size();
    endtask

    task automatic build_request(input int len);
        int i;
        pkt.delete();
        pkt.push_back(REQ_TYPE[15:8]);
        pkt.push_back(REQ_TYPE[7:0]);
        pkt.push_back(byte_t'($urandom));
        pkt.push_back(byte_t'($urandom));
        for (i = 0; i < 4; i++) pkt.push_back(COOKIE[31 - 8 * i -: 8]);
        while (pkt.size() < len || pkt.size() < HDR_BYTES) pkt.push_back(byte_t'($urandom));
        while (pkt.size() > len) void'(pkt.pop_back());
    endtask

    task automatic build_noise(input int len);
        pkt.delete();
        repeat (len) pkt.push_back(byte_t'($urandom));
    endtask

    task automatic test_directed();
        build_request(HDR_BYTES);
        send_datagram(32'h0000_0000, 16'h0000, 1'b0);
        // runs past the point where the byte count saturates
        build_request(33);
        send_datagram(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        build_request(HDR_BYTES - 1);
        send_datagram($urandom, 16'($urandom), 1'b0);
        build_request(1);
        send_datagram($urandom, 16'($urandom), 1'b0);
        build_request(HDR_BYTES);
        pkt[0] = REQ_TYPE[7:0];
        send_datagram($urandom, 16'($urandom), 1'b0);
        build_request(HDR_BYTES);
        pkt[1] = 8'h00;
        send_datagram($urandom, 16'($urandom), 1'b0);
        build_request(HDR_BYTES);
        pkt[7] = pkt[7] ^ 8'h01;
        send_datagram($urandom, 16'($urandom), 1'b0);
        build_request(24);
        send_datagram($urandom, 16'($urandom), 1'b1);
    endtask

    // short requests against a stalled receiver fill the pending queue
    task automatic test_backpressure();
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (4) begin
            build_request(HDR_BYTES);
            send_datagram($urandom, 16'($urandom), 1'b0);
        end
        calm = 1'b0;
    endtask

    task automatic test_random();
        int start;
        int kind;
        int pos;
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            calm = (sent_bytes - start >= RANDOM_BYTES - CALM_BYTES);
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 3) == 0) build_request($urandom_range(33, 45));
                else build_request($urandom_range(HDR_BYTES, 32));
                send_datagram($urandom, 16'($urandom), 1'b0);
            end else if (kind == 6) begin
                build_request($urandom_range(1, HDR_BYTES - 1));
                send_datagram($urandom, 16'($urandom), 1'b0);
            end else if (kind == 7) begin
                // spoil one header byte; the length bytes are not checked
                build_request($urandom_range(HDR_BYTES, 28));
                pos      = $urandom_range(0, 7);
                pkt[pos] = pkt[pos] ^ byte_t'($urandom_range(1, 255));
                send_datagram($urandom, 16'($urandom), 1'b0);
            end else if (kind == 8) begin
                build_noise($urandom_range(1, 40));
                send_datagram($urandom, 16'($urandom), 1'b0);
            end else begin
                build_request($urandom_range(HDR_BYTES, 30));
                send_datagram($urandom, 16'($urandom), 1'b1);
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        s_tvalid = 1'b0;
        while (response_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("stun_binding_responder_test passed");
        else
            $display("stun_binding_responder_test failed");
        $finish;
    end

endmodule
